### rtl/srs_pkg.sv
// shared constants for the servo recipe sequencer
// operation codes, recipe opcodes, field widths and the default recipe depth
// no dependencies
package srs_pkg;

   localparam int OP_W    = 3;
   localparam int ADDR_W  = 5;
   localparam int WORD_W  = 8;
   localparam int ARG_W   = 5;
   localparam int POS_W   = 3;
   localparam int DUTY_W  = 4;
   localparam int PC_W    = 5;

   localparam int DEFAULT_PROGRAM_DEPTH = 32;

   localparam logic [POS_W-1:0] MAX_POS = 3'd5;

   typedef logic [OP_W-1:0] op_type;
   typedef logic [2:0]      opcode_type;

   // channel operations
   localparam op_type OP_TICK       = 3'd0;
   localparam op_type OP_RESTART    = 3'd1;
   localparam op_type OP_RESUME     = 3'd2;
   localparam op_type OP_PAUSE      = 3'd3;
   localparam op_type OP_STEP_UP    = 3'd4;
   localparam op_type OP_STEP_DOWN  = 3'd5;
   localparam op_type OP_WRITE      = 3'd6;
   localparam op_type OP_NOP        = 3'd7;

   // recipe opcodes
   localparam opcode_type OPC_END        = 3'd0;
   localparam opcode_type OPC_MOVE       = 3'd1;
   localparam opcode_type OPC_WAIT       = 3'd2;
   localparam opcode_type OPC_FLIP       = 3'd3;
   localparam opcode_type OPC_LOOP_START = 3'd4;
   localparam opcode_type OPC_LOOP_END   = 3'd5;
   localparam opcode_type OPC_SKIP       = 3'd6;
   localparam opcode_type OPC_BAD        = 3'd7;

   // error flag bits
   localparam int ERR_OPCODE_BIT = 0;
   localparam int ERR_MOVE_BIT   = 1;
   localparam int ERR_LOOP_BIT   = 2;

endpackage

### rtl/servo_recipe_sequencer_top.sv
// servo recipe sequencer: one servo channel stepping through a byte-coded recipe
// depends on srs_pkg
// a registered result word appears the cycle after its request word is accepted
// throughput: one request word per cycle unless stalled; the recipe memory
// read is prefetched into a register for the next instruction, with write bypass
// reset: synchronous, active high; clears sequencer state, pauses the channel;
// recipe memory contents are undefined until written
module servo_recipe_sequencer_top #(
   parameter int PROGRAM_DEPTH = srs_pkg::DEFAULT_PROGRAM_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [srs_pkg::OP_W-1:0]     req_operation,
   input  logic [srs_pkg::ADDR_W-1:0]   req_program_address,
   input  logic [srs_pkg::WORD_W-1:0]   req_program_word,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [srs_pkg::POS_W-1:0]    rsp_position,
   output logic [srs_pkg::DUTY_W-1:0]   rsp_duty_percent,
   output logic [srs_pkg::PC_W-1:0]     rsp_program_counter,
   output logic                         rsp_opcode_error,
   output logic                         rsp_move_error,
   output logic                         rsp_loop_error,
   output logic                         rsp_recipe_done,
   output logic                         rsp_paused
);
   import srs_pkg::*;

   localparam int AW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
   localparam int SW = ((AW > ARG_W) ? AW : ARG_W) + 1;
   localparam int WRAP_STEPS = (PROGRAM_DEPTH + 31) / PROGRAM_DEPTH;

   // reduce a short sum into the recipe index range
   function automatic logic [AW-1:0] wrap_index(input logic [SW-1:0] value);
      logic [SW-1:0] v;
      v = value;
      for (int i = 0; i < WRAP_STEPS; i++) begin
         if (v >= SW'(PROGRAM_DEPTH)) begin
            v = v - SW'(PROGRAM_DEPTH);
         end
      end
      return v[AW-1:0];
   endfunction

   logic [WORD_W-1:0] recipe_mem [PROGRAM_DEPTH];

   logic [WORD_W-1:0] word_ff;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     body_ff, body_in;
   logic [ARG_W-1:0]  loop_cnt_ff, loop_cnt_in;
   logic [ARG_W-1:0]  wait_cnt_ff, wait_cnt_in;
   logic [ARG_W-1:0]  travel_ff, travel_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              complete_ff, complete_in;
   logic              pause_ff, pause_in;
   logic              end_ff, end_in;
   logic [2:0]        err_ff, err_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_position_ff;
   logic [DUTY_W-1:0] rsp_duty_ff;
   logic [PC_W-1:0]   rsp_pc_ff;
   logic [2:0]        rsp_err_ff;
   logic              rsp_done_ff;
   logic              rsp_paused_ff;

   logic              accept;
   logic              halted;
   opcode_type        opc;
   logic [ARG_W-1:0]  arg;
   logic [ARG_W-1:0]  move_target;
   logic [ARG_W-1:0]  move_start;
   logic [ARG_W-1:0]  move_travel;
   logic              move_done;
   logic              move_bad;
   logic [ARG_W-1:0]  wait_next;
   logic [ARG_W:0]    step_add;
   logic [AW-1:0]     seq_next;
   logic [AW-1:0]     idx_plus_one;
   logic              wr_en;
   logic [AW-1:0]     wr_index;
   logic [SW-1:0]     pc_wide;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign halted    = pause_ff || end_ff || (err_ff != 3'b000);

   assign opc = word_ff[WORD_W-1 -: 3];
   assign arg = word_ff[ARG_W-1:0];

   // move and flip share the travel logic
   assign move_target = (opc == OPC_FLIP)
      ? (complete_ff ? ARG_W'(MAX_POS - pos_ff) : ARG_W'(pos_ff))
      : arg;
   assign move_start  = complete_ff ? ARG_W'(pos_ff) : travel_ff;
   assign move_done   = (move_start == move_target);
   assign move_bad    = (move_target > ARG_W'(MAX_POS));
   assign move_travel = (move_start > move_target) ? move_start - 1'b1
                      : (move_start < move_target) ? move_start + 1'b1
                      : move_start;

   assign wait_next = complete_ff ? arg
                    : (wait_cnt_ff != '0) ? wait_cnt_ff - 1'b1
                    : wait_cnt_ff;

   always_comb begin
      step_add = '0;
      case (opc)
         OPC_MOVE, OPC_FLIP: begin
            step_add = (ARG_W+1)'(move_done);
         end
         OPC_WAIT: begin
            step_add = (ARG_W+1)'(wait_next == '0);
         end
         OPC_LOOP_START: begin
            step_add = (ARG_W+1)'((loop_cnt_ff == '0) || complete_ff);
         end
         OPC_LOOP_END: begin
            step_add = (ARG_W+1)'(1'b1);
         end
         OPC_SKIP: begin
            step_add = (ARG_W+1)'(arg) + (ARG_W+1)'(complete_ff);
         end
         OPC_BAD: begin
            step_add = (ARG_W+1)'(complete_ff);
         end
         default: begin
            step_add = '0;
         end
      endcase
   end

   assign seq_next     = wrap_index(SW'(idx_ff) + SW'(step_add));
   assign idx_plus_one = wrap_index(SW'(idx_ff) + SW'(1'b1));
   assign wr_index     = wrap_index(SW'(req_program_address));
   assign wr_en        = accept && (req_operation == OP_WRITE);

   always_comb begin
      idx_in      = idx_ff;
      body_in     = body_ff;
      loop_cnt_in = loop_cnt_ff;
      wait_cnt_in = wait_cnt_ff;
      travel_in   = travel_ff;
      pos_in      = pos_ff;
      complete_in = complete_ff;
      pause_in    = pause_ff;
      end_in      = end_ff;
      err_in      = err_ff;
      if (accept) begin
         case (req_operation)
            OP_TICK: begin
               if (!halted) begin
                  case (opc)
                     OPC_END: begin
                        end_in      = 1'b1;
                        complete_in = 1'b0;
                     end
                     OPC_MOVE, OPC_FLIP: begin
                        if (move_bad) begin
                           err_in[ERR_MOVE_BIT] = 1'b1;
                           pos_in = MAX_POS;
                        end else begin
                           pos_in = move_target[POS_W-1:0];
                        end
                        travel_in   = move_travel;
                        complete_in = move_done;
                        idx_in      = seq_next;
                     end
                     OPC_WAIT: begin
                        wait_cnt_in = wait_next;
                        complete_in = (wait_next == '0);
                        idx_in      = seq_next;
                     end
                     OPC_LOOP_START: begin
                        if (loop_cnt_ff == '0) begin
                           body_in     = idx_plus_one;
                           loop_cnt_in = arg;
                           complete_in = 1'b1;
                        end else begin
                           err_in[ERR_LOOP_BIT] = 1'b1;
                        end
                        idx_in = seq_next;
                     end
                     OPC_LOOP_END: begin
                        complete_in = 1'b1;
                        if (loop_cnt_ff != '0) begin
                           idx_in      = body_ff;
                           loop_cnt_in = loop_cnt_ff - 1'b1;
                        end else begin
                           idx_in = seq_next;
                        end
                     end
                     OPC_SKIP: begin
                        idx_in = seq_next;
                     end
                     default: begin
                        err_in[ERR_OPCODE_BIT] = 1'b1;
                        idx_in = seq_next;
                     end
                  endcase
               end
            end
            OP_RESTART: begin
               pos_in      = '0;
               idx_in      = '0;
               body_in     = '0;
               loop_cnt_in = '0;
               wait_cnt_in = '0;
               travel_in   = '0;
               complete_in = 1'b1;
               end_in      = 1'b0;
               err_in      = '0;
            end
            OP_RESUME: begin
               pause_in = 1'b0;
            end
            OP_PAUSE: begin
               pause_in = 1'b1;
            end
            OP_STEP_UP: begin
               if (pause_ff && (pos_ff < MAX_POS)) begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            OP_STEP_DOWN: begin
               if (pause_ff && (pos_ff != '0)) begin
                  pos_in = pos_ff - 1'b1;
               end
            end
            default: begin
               idx_in = idx_ff;
            end
         endcase
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         body_ff      <= '0;
         loop_cnt_ff  <= '0;
         wait_cnt_ff  <= '0;
         travel_ff    <= '0;
         pos_ff       <= '0;
         complete_ff  <= 1'b1;
         pause_ff     <= 1'b1;
         end_ff       <= 1'b0;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         body_ff      <= body_in;
         loop_cnt_ff  <= loop_cnt_in;
         wait_cnt_ff  <= wait_cnt_in;
         travel_ff    <= travel_in;
         pos_ff       <= pos_in;
         complete_ff  <= complete_in;
         pause_ff     <= pause_in;
         end_ff       <= end_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // recipe memory with prefetch of the next instruction
   always_ff @(posedge clock) begin
      if (wr_en) begin
         recipe_mem[wr_index] <= req_program_word;
      end
      if (wr_en && (wr_index == idx_in)) begin
         word_ff <= req_program_word;
      end else begin
         word_ff <= recipe_mem[idx_in];
      end
   end

   assign pc_wide = SW'(idx_in);

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_position_ff <= pos_in;
         rsp_duty_ff     <= DUTY_W'({pos_in, 1'b0}) + DUTY_W'(2);
         rsp_pc_ff       <= pc_wide[PC_W-1:0];
         rsp_err_ff      <= err_in;
         rsp_done_ff     <= end_in;
         rsp_paused_ff   <= pause_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_position        = rsp_position_ff;
   assign rsp_duty_percent    = rsp_duty_ff;
   assign rsp_program_counter = rsp_pc_ff;
   assign rsp_opcode_error    = rsp_err_ff[ERR_OPCODE_BIT];
   assign rsp_move_error      = rsp_err_ff[ERR_MOVE_BIT];
   assign rsp_loop_error      = rsp_err_ff[ERR_LOOP_BIT];
   assign rsp_recipe_done     = rsp_done_ff;
   assign rsp_paused          = rsp_paused_ff;

endmodule
